### rtl/utf8dec_pkg.sv
package utf8dec_pkg;

	localparam int BYTE_W  = 8;
	localparam int CP_W    = 21;
	localparam int COUNT_W = 32;
	localparam int RUN_W   = 3;
	localparam int SLOT_W  = 2;

	localparam int QUEUE_DEPTH_DEFAULT = 4;

	localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;

	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;
	localparam logic [BYTE_W-1:0] PAYLOAD6   = 8'h3F;

	// one accepted byte worth of results: replacements everywhere except value_pos when has_value is set
	typedef struct packed {
		logic [RUN_W-1:0]  count;
		logic              has_value;
		logic [SLOT_W-1:0] value_pos;
		logic [CP_W-1:0]   value;
		logic              text_end;
	} job_t;

endpackage

### rtl/utf8dec_if.sv
interface utf8dec_text_if;
	logic                             valid;
	logic                             ready;
	logic [utf8dec_pkg::BYTE_W-1:0]   text_byte;
	logic                             end_of_text;
	modport source (output valid, text_byte, end_of_text, input ready);
	modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface utf8dec_point_if;
	logic                             valid;
	logic                             ready;
	logic [utf8dec_pkg::CP_W-1:0]     code_point;
	logic                             last_of_run;
	logic                             text_done;
	logic [utf8dec_pkg::COUNT_W-1:0]  points_so_far;
	modport source (output valid, code_point, last_of_run, text_done, points_so_far,
		input ready);
	modport sink (input valid, code_point, last_of_run, text_done, points_so_far,
		output ready);
endinterface

interface utf8dec_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [utf8dec_pkg::CP_W-1:0]     replacement_value;
	modport source (output valid, replacement_value, input ready);
	modport sink (input valid, replacement_value, output ready);
endinterface

### rtl/utf8dec_front.sv
module utf8dec_front (
	input  logic                clk,
	input  logic                arst_n,
	utf8dec_text_if.sink        text,
	input  logic                full,
	output logic                push,
	output utf8dec_pkg::job_t   push_job
);
	import utf8dec_pkg::*;

	logic [1:0]        held_q;
	logic [1:0]        need_q;
	logic [CP_W-1:0]   part_q;

	logic [1:0]        held_n;
	logic [1:0]        need_n;
	logic [CP_W-1:0]   part_n;
	logic [CP_W-1:0]   part_c;
	logic [RUN_W-1:0]  nrep;
	logic [BYTE_W-1:0] b;
	logic              is_cont;
	logic              accept;
	job_t              job;

	assign b          = text.text_byte;
	assign is_cont    = (b & CONT_MASK) == CONT_TAG;
	assign text.ready = !full;
	assign accept     = text.valid && !full;
	assign part_c     = {part_q[CP_W-7:0], b[5:0] & PAYLOAD6[5:0]};
	assign nrep       = {1'b0, held_q};

	always_comb begin
		job    = '0;
		held_n = held_q;
		need_n = need_q;
		part_n = part_q;
		if (held_q != 2'd0 && is_cont) begin
			if (need_q == 2'd1) begin
				// sequence complete
				job.count     = RUN_W'(1);
				job.has_value = !(part_c > CP_MAX || (part_c >= SURR_LO && part_c <= SURR_HI));
				job.value     = part_c;
				held_n        = 2'd0;
				need_n        = 2'd0;
				part_n        = '0;
			end else begin
				held_n = held_q + 2'd1;
				need_n = need_q - 2'd1;
				part_n = part_c;
				if (text.end_of_text) begin
					job.count = nrep + RUN_W'(1);
				end
			end
		end else begin
			// flush whatever is held, then take the byte fresh
			held_n = 2'd0;
			need_n = 2'd0;
			part_n = '0;
			if (!b[BYTE_W-1]) begin
				job.count     = nrep + RUN_W'(1);
				job.has_value = 1'b1;
				job.value_pos = held_q;
				job.value     = {{(CP_W-BYTE_W){1'b0}}, b};
			end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
				held_n    = 2'd1;
				need_n    = 2'd1;
				part_n    = {{(CP_W-5){1'b0}}, b[4:0]};
				job.count = nrep + {{(RUN_W-1){1'b0}}, text.end_of_text};
			end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
				held_n    = 2'd1;
				need_n    = 2'd2;
				part_n    = {{(CP_W-4){1'b0}}, b[3:0]};
				job.count = nrep + {{(RUN_W-1){1'b0}}, text.end_of_text};
			end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
				held_n    = 2'd1;
				need_n    = 2'd3;
				part_n    = {{(CP_W-3){1'b0}}, b[2:0]};
				job.count = nrep + {{(RUN_W-1){1'b0}}, text.end_of_text};
			end else begin
				job.count = nrep + RUN_W'(1);
			end
		end
		if (text.end_of_text) begin
			held_n = 2'd0;
			need_n = 2'd0;
			part_n = '0;
		end
		job.text_end = text.end_of_text;
	end

	assign push     = accept && (job.count != '0);
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
			need_q <= 2'd0;
			part_q <= '0;
		end else if (accept) begin
			held_q <= held_n;
			need_q <= need_n;
			part_q <= part_n;
		end
	end

	// an open sequence always waits for at least one continuation
	assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != 2'd0) |-> (need_q != 2'd0))
		else $error("open sequence with nothing pending");

	// no sequence open means nothing pending and nothing assembled
	assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == 2'd0) |-> (need_q == 2'd0 && part_q == '0))
		else $error("stale sequence state while idle");

	// end of text always yields at least one result
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && text.end_of_text) |-> push)
		else $error("end of text produced no result");

endmodule

### rtl/utf8dec_queue.sv
module utf8dec_queue #(
	parameter int DEPTH = utf8dec_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  utf8dec_pkg::job_t   push_job,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output utf8dec_pkg::job_t   head_job
);
	import utf8dec_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   fill_q;

	assign full       = fill_q == (AW+1)'(DEPTH);
	assign head_valid = fill_q != '0;
	assign head_job   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (AW+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (AW+1)'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("request pushed into full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop)
		else $error("pop from empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (AW+1)'(DEPTH))
		else $error("queue fill out of range");

endmodule

### rtl/utf8dec_back.sv
module utf8dec_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  utf8dec_pkg::job_t             head_job,
	output logic                          pop,
	input  logic [utf8dec_pkg::CP_W-1:0]  repl,
	utf8dec_point_if.source               points
);
	import utf8dec_pkg::*;

	logic               out_valid_q;
	logic [CP_W-1:0]    code_q;
	logic               last_q;
	logic               done_q;
	logic [COUNT_W-1:0] pts_q;
	logic [SLOT_W-1:0]  idx_q;
	logic [COUNT_W-1:0] count_q;

	logic               load;
	logic               slot_last;
	logic [COUNT_W-1:0] cnt_inc;

	assign load      = head_valid && (!out_valid_q || points.ready);
	assign slot_last = {1'b0, idx_q} == (head_job.count - RUN_W'(1));
	assign cnt_inc   = (&count_q) ? count_q : count_q + COUNT_W'(1);
	assign pop       = load && slot_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			count_q     <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= slot_last ? '0 : idx_q + SLOT_W'(1);
			count_q     <= (slot_last && head_job.text_end) ? '0 : cnt_inc;
		end else if (points.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= (head_job.has_value && head_job.value_pos == idx_q)
				? head_job.value : repl;
			last_q <= slot_last;
			done_q <= slot_last && head_job.text_end;
			pts_q  <= cnt_inc;
		end
	end

	assign points.valid         = out_valid_q;
	assign points.code_point    = code_q;
	assign points.last_of_run   = last_q;
	assign points.text_done     = done_q;
	assign points.points_so_far = pts_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (head_job.count != '0 && head_job.count <= RUN_W'(4)))
		else $error("queued request with bad result count");

	assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ({1'b0, idx_q} < head_job.count))
		else $error("slot index past end of request");

	assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> head_valid)
		else $error("request left mid-run");

endmodule

### rtl/utf8_stream_decoder.sv
// channel   role   payload
// text      sink   text_byte[7:0], end_of_text
// points    source code_point[20:0], last_of_run, text_done, points_so_far[31:0]
// cfg       sink   replacement_value[20:0]
//
// one byte accepted per cycle while the request queue has room
// the back end emits one code point per cycle unless points.ready stalls it, so a byte
// causing n results (1 to 4) holds it for n code points; the queue absorbs these bursts
// results pass through the request queue and then the output register
// arst_n clears the open sequence, the queue, the output valid and the count
// cfg is always ready; replacement_value resets to fffd
module utf8_stream_decoder #(
	parameter int QUEUE_DEPTH = utf8dec_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	utf8dec_text_if.sink    text,
	utf8dec_point_if.source points,
	utf8dec_cfg_if.sink     cfg
);
	import utf8dec_pkg::*;

	logic [CP_W-1:0] repl_q;
	logic            full;
	logic            push;
	job_t            push_job;
	logic            pop;
	logic            head_valid;
	job_t            head_job;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
		end else if (cfg.valid) begin
			repl_q <= cfg.replacement_value;
		end
	end

	utf8dec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.full     (full),
		.push     (push),
		.push_job (push_job)
	);

	utf8dec_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	utf8dec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.repl       (repl_q),
		.points     (points)
	);

endmodule
